@@ sv/dpr_pkg.sv @@
// Package for the delimited packet receiver.
// Holds the request kind codes and configuration register indexes; no dependencies.
`default_nettype none

package dpr_pkg;

    localparam int unsigned KIND_W  = 2;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 7;
    localparam int unsigned CFG_W   = 2;

    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [CFG_W-1:0]   cfg_index_t;

    localparam kind_t KIND_RX   = 2'd0;
    localparam kind_t KIND_READ = 2'd1;
    localparam kind_t KIND_TAKE = 2'd2;

    localparam cfg_index_t CFG_START = 2'd0;
    localparam cfg_index_t CFG_END   = 2'd1;
    localparam cfg_index_t CFG_TERM  = 2'd2;

    localparam byte_t START_RESET = 8'h40;
    localparam byte_t END_RESET   = 8'h23;
    localparam byte_t TERM_RESET  = 8'h2E;

endpackage

`default_nettype wire

@@ sv/dpr_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module dpr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sv/delimited_packet_receiver_core.sv @@
// Throughput: one item per cycle while in_stall is low; the payload RAM has one write and one read port.
// Reset clears phase, count and flags and loads the delimiter registers; the
// payload RAM is not cleared, as only entries below the current length are read.
// Depends on dpr_pkg and dpr_ram.
`default_nettype none

module delimited_packet_receiver_core #(
    parameter int unsigned PAYLOAD_DEPTH = 128
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire dpr_pkg::kind_t     kind,
    input  wire dpr_pkg::byte_t     rx_byte,
    input  wire dpr_pkg::index_t    read_index,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output dpr_pkg::byte_t          read_data,
    output logic                    ready_res,
    output logic [7:0]              length,
    output logic                    overflow,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire dpr_pkg::cfg_index_t cfg_index,
    input  wire dpr_pkg::byte_t     cfg_data
);

    import dpr_pkg::*;

    localparam int unsigned AW = $clog2(PAYLOAD_DEPTH);
    localparam int unsigned CW = $clog2(PAYLOAD_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_TAIL    = 2'd2
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            ready_reg, ready_next;
    logic            drop_reg, drop_next;
    byte_t           start_reg, end_reg, term_reg;

    logic            s1_valid_reg;
    logic            s1_rd_reg;
    logic            s1_ready_reg;
    logic [7:0]      s1_len_reg;
    logic            s1_ovf_reg;

    logic            out_valid_reg;
    byte_t           read_data_reg;
    logic            ready_res_reg;
    logic [7:0]      length_reg;
    logic            overflow_reg;

    logic            out_free;
    logic            s1_adv;
    logic            accept;
    logic            wr_en;
    logic            rd_en;
    byte_t           ram_q;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // A read is only enabled below the current count, and the write goes to
    // the entry at the count, so the two ports never touch the same entry.
    assign rd_en = accept && (kind == KIND_READ)
                   && (32'(read_index) < 32'(count_reg));

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        ready_next = ready_reg;
        drop_next  = drop_reg;
        wr_en      = 1'b0;
        if (kind == KIND_RX)
        begin
            unique case (phase_reg)
                PH_PAYLOAD:
                begin
                    if (rx_byte == end_reg)
                    begin
                        phase_next = PH_TAIL;
                    end
                    else if (32'(count_reg) < PAYLOAD_DEPTH)
                    begin
                        wr_en      = accept;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
                PH_TAIL:
                begin
                    if (rx_byte == term_reg)
                    begin
                        phase_next = PH_IDLE;
                        ready_next = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (rx_byte == start_reg && !ready_reg)
                    begin
                        phase_next = PH_PAYLOAD;
                        count_next = '0;
                        drop_next  = 1'b0;
                    end
                end
            endcase
        end
        else if (kind == KIND_TAKE)
        begin
            ready_next = 1'b0;
        end
    end

    dpr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAYLOAD_DEPTH)
    ) u_payload_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (rx_byte),
        .re    (rd_en),
        .raddr (AW'(read_index)),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            ready_reg     <= 1'b0;
            drop_reg      <= 1'b0;
            start_reg     <= START_RESET;
            end_reg       <= END_RESET;
            term_reg      <= TERM_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_START: start_reg <= cfg_data;
                    CFG_END:   end_reg   <= cfg_data;
                    CFG_TERM:  term_reg  <= cfg_data;
                    default:   ;
                endcase
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                ready_reg <= ready_next;
                drop_reg  <= drop_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rd_reg    <= rd_en;
            s1_ready_reg <= ready_reg;
            s1_len_reg   <= 8'(count_next);
            s1_ovf_reg   <= drop_next;
        end
        if (s1_adv)
        begin
            read_data_reg <= s1_rd_reg ? ram_q : '0;
            ready_res_reg <= s1_ready_reg;
            length_reg    <= s1_len_reg;
            overflow_reg  <= s1_ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign ready_res = ready_res_reg;
    assign length    = length_reg;
    assign overflow  = overflow_reg;

endmodule

`default_nettype wire

@@ sv/dpr_checker.sv @@
// Port-level assertions for the delimited packet receiver, with the bind that
// attaches them to delimited_packet_receiver_core. Depends on dpr_pkg.
`default_nettype none

module dpr_checker #(
    parameter int unsigned PAYLOAD_DEPTH = 128
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_stall,
    input  wire logic                out_valid,
    input  wire logic                out_stall,
    input  wire dpr_pkg::byte_t      read_data,
    input  wire logic                ready_res,
    input  wire logic [7:0]          length,
    input  wire logic                overflow
);

    import dpr_pkg::*;

    // An empty output side never holds back the input side.
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output register empty");

    // Bytes are only dropped once the store is full.
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> length == 8'(PAYLOAD_DEPTH))
        else $error("overflow reported below full length");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(read_data) && $stable(length)
            && $stable(ready_res) && $stable(overflow))
        else $error("stalled result changed");

endmodule

bind delimited_packet_receiver_core dpr_checker #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
) u_dpr_checker (.*);

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for delimited_packet_receiver_core: directed framing and overflow
// cases, output hold-off, and random packet traffic over several delimiter settings.
// Depends on dpr_pkg and the core RTL; results are checked against an in-line deframer model.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dpr_pkg::*;

    localparam int DEPTH        = 128;
    localparam int PIPE_LATENCY = 2;
    localparam int CYCLE_LIMIT  = 400000;

    localparam kind_t      KIND_UNUSED = 2'd3;
    localparam cfg_index_t CFG_SPARE   = 2'd3;

    typedef enum logic [1:0] {PH_IDLE, PH_BODY, PH_TAIL} frame_phase_t;

    typedef struct packed {
        byte_t      data;
        logic       ready;
        logic [7:0] len;
        logic       ovf;
    } deframe_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    kind_t      kind;
    byte_t      rx_byte;
    index_t     read_index;
    logic       out_valid;
    logic       out_stall;
    byte_t      read_data;
    logic       ready_res;
    logic [7:0] length;
    logic       overflow;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_index_t cfg_index;
    byte_t      cfg_data;

    byte_t        start_sym;
    byte_t        end_sym;
    byte_t        term_sym;
    frame_phase_t frame_phase;
    int           body_len;
    byte_t        body_mem [DEPTH];
    logic         pkt_ready;
    logic         dropped;

    deframe_result_t pending_results [$];
    int              errors;
    int              items_sent;
    int              burst_left;
    int              holdoff_request;

    delimited_packet_receiver_core #(
        .PAYLOAD_DEPTH(DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .rx_byte   (rx_byte),
        .read_index(read_index),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .read_data (read_data),
        .ready_res (ready_res),
        .length    (length),
        .overflow  (overflow),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic byte_t rand_byte();
        return byte_t'($urandom_range(0, 255));
    endfunction

    function automatic index_t rand_index();
        return index_t'($urandom_range(0, DEPTH - 1));
    endfunction

    function automatic byte_t body_byte();
        byte_t v;
        do
            v = rand_byte();
        while (v == end_sym);
        return v;
    endfunction

    function automatic deframe_result_t deframe_step(kind_t k, byte_t b, index_t idx);
        deframe_result_t r;
        r.data  = '0;
        r.ready = pkt_ready;
        if (k == KIND_RX)
        begin
            case (frame_phase)
                PH_BODY:
                begin
                    if (b == end_sym)
                        frame_phase = PH_TAIL;
                    else if (body_len < DEPTH)
                    begin
                        body_mem[body_len] = b;
                        body_len++;
                    end
                    else
                        dropped = 1'b1;
                end
                PH_TAIL:
                begin
                    if (b == term_sym)
                    begin
                        frame_phase = PH_IDLE;
                        pkt_ready   = 1'b1;
                    end
                end
                default:
                begin
                    frame_phase = PH_IDLE;
                    if (b == start_sym && !pkt_ready)
                    begin
                        frame_phase = PH_BODY;
                        body_len    = 0;
                        dropped     = 1'b0;
                    end
                end
            endcase
        end
        else if (k == KIND_READ)
        begin
            if (int'(idx) < body_len)
                r.data = body_mem[idx];
        end
        else if (k == KIND_TAKE)
            pkt_ready = 1'b0;
        r.len = 8'(body_len);
        r.ovf = dropped;
        return r;
    endfunction

    task automatic send_item(kind_t k, byte_t b, index_t idx);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        kind       <= k;
        rx_byte    <= b;
        read_index <= idx;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        pending_results.push_back(deframe_step(k, b, idx));
        items_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    task automatic program_delimiters(byte_t s, byte_t e, byte_t t);
        cfg_index_t slots [4];
        byte_t      values [4];
        slots  = '{CFG_START, CFG_END, CFG_TERM, CFG_SPARE};
        values = '{s, e, t, rand_byte()};
        for (int n = 0; n < 4; n++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= slots[n];
            cfg_data  <= values[n];
            @(posedge clk);
            while (cfg_ready !== 1'b1)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        start_sym = s;
        end_sym   = e;
        term_sym  = t;
        @(posedge clk);
    endtask

    task automatic send_packet(int n_body, bit complete);
        byte_t v;
        int    extra;
        if (pkt_ready && $urandom_range(0, 9) != 0)
            send_item(KIND_TAKE, rand_byte(), rand_index());
        send_item(KIND_RX, start_sym, rand_index());
        for (int n = 0; n < n_body; n++)
            send_item(KIND_RX, body_byte(), rand_index());
        if (!complete && $urandom_range(0, 1) == 0)
            return;
        send_item(KIND_RX, end_sym, rand_index());
        extra = $urandom_range(0, 3);
        for (int n = 0; n < extra; n++)
        begin
            do
                v = rand_byte();
            while (v == term_sym);
            send_item(KIND_RX, v, rand_index());
        end
        if (!complete)
            return;
        send_item(KIND_RX, term_sym, rand_index());
        extra = $urandom_range(0, 5);
        for (int n = 0; n < extra; n++)
        begin
            if (body_len > 0 && $urandom_range(0, 3) != 0)
                send_item(KIND_READ, rand_byte(), index_t'($urandom_range(0, body_len - 1)));
            else
                send_item(KIND_READ, rand_byte(), rand_index());
        end
        if ($urandom_range(0, 4) != 0)
            send_item(KIND_TAKE, rand_byte(), rand_index());
    endtask

    task automatic run_mixed_traffic(int quota);
        int stop_at;
        int pick;
        int n_body;
        int noise;
        stop_at = items_sent + quota;
        while (items_sent < stop_at)
        begin
            pick   = $urandom_range(0, 99);
            n_body = ($urandom_range(0, 99) == 0) ? $urandom_range(100, DEPTH + 8)
                                                  : $urandom_range(0, 16);
            if (pick < 65)
                send_packet(n_body, 1'b1);
            else if (pick < 78)
                send_packet(n_body, 1'b0);
            else if (pick < 98)
            begin
                noise = $urandom_range(1, 8);
                for (int n = 0; n < noise; n++)
                    send_item(kind_t'($urandom_range(0, 3)), rand_byte(), rand_index());
            end
            else
                drain_results();
        end
        drain_results();
    endtask

    task automatic test_reset_framing();
        send_item(KIND_TAKE, 8'h00, 7'h00);
        send_item(KIND_RX, 8'h00, 7'h7F);
        send_item(KIND_RX, start_sym, 7'h00);
        send_item(KIND_RX, 8'h00, rand_index());
        send_item(KIND_RX, 8'hFF, rand_index());
        send_item(KIND_RX, term_sym, rand_index());
        send_item(KIND_RX, start_sym, rand_index());
        send_item(KIND_RX, end_sym, rand_index());
        send_item(KIND_RX, 8'hFF, rand_index());
        send_item(KIND_RX, start_sym, rand_index());
        send_item(KIND_RX, term_sym, rand_index());
        send_item(KIND_RX, start_sym, rand_index());
        send_item(KIND_RX, 8'h55, rand_index());
        send_item(KIND_READ, 8'hFF, 7'd0);
        send_item(KIND_READ, 8'h00, 7'd3);
        send_item(KIND_READ, 8'hA5, 7'd4);
        send_item(KIND_READ, 8'h5A, 7'h7F);
        send_item(KIND_UNUSED, 8'hFF, 7'h7F);
        send_item(KIND_TAKE, 8'hFF, 7'h7F);
        send_item(KIND_TAKE, 8'h00, 7'h00);
        drain_results();
    endtask

    task automatic test_payload_overflow();
        send_item(KIND_RX, start_sym, rand_index());
        for (int n = 0; n < DEPTH + 6; n++)
            send_item(KIND_RX, body_byte(), rand_index());
        send_item(KIND_READ, rand_byte(), 7'd0);
        send_item(KIND_READ, rand_byte(), 7'h7F);
        send_item(KIND_RX, end_sym, rand_index());
        send_item(KIND_RX, term_sym, rand_index());
        send_item(KIND_READ, rand_byte(), rand_index());
        send_item(KIND_TAKE, rand_byte(), rand_index());
        send_packet(1, 1'b1);
        drain_results();
    endtask

    task automatic test_output_holdoff();
        holdoff_request = 300;
        for (int n = 0; n < 6; n++)
            send_packet($urandom_range(2, 10), 1'b1);
        drain_results();
    endtask

    task automatic test_delimiter_sweep();
        byte_t presets [5][3];
        presets = '{'{8'h00, 8'hFF, 8'h80},
                    '{8'hFF, 8'h00, 8'h01},
                    '{8'hAA, 8'hAA, 8'h55},
                    '{8'h12, 8'h7E, 8'h7E},
                    '{START_RESET, END_RESET, TERM_RESET}};
        for (int n = 0; n < 3; n++)
        begin
            program_delimiters(rand_byte(), rand_byte(), rand_byte());
            run_mixed_traffic(205);
        end
        for (int n = 0; n < 5; n++)
        begin
            program_delimiters(presets[n][0], presets[n][1], presets[n][2]);
            run_mixed_traffic(205);
        end
    endtask

    task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    initial
    begin : result_checker
        deframe_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual data %0d len %0d",
                             $time, read_data, length);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("read_data", want.data, read_data);
                    compare_field("ready_res", 8'(want.ready), 8'(ready_res));
                    compare_field("length", want.len, length);
                    compare_field("overflow", 8'(want.ovf), 8'(overflow));
                end
            end
        end
    end

    initial
    begin : receiver
        int hold_left;
        int mode_left;
        int stall_pct;
        int pct_choices [5];
        pct_choices = '{0, 10, 30, 60, 90};
        hold_left = 0;
        mode_left = 0;
        stall_pct = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_request > 0)
            begin
                hold_left       = holdoff_request;
                holdoff_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(8, 80);
                    stall_pct = pct_choices[$urandom_range(0, 4)];
                end
                mode_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench failed");
        $finish;
    end

    initial
    begin
        errors          = 0;
        items_sent      = 0;
        burst_left      = 0;
        holdoff_request = 0;
        start_sym       = START_RESET;
        end_sym         = END_RESET;
        term_sym        = TERM_RESET;
        frame_phase     = PH_IDLE;
        body_len        = 0;
        pkt_ready       = 1'b0;
        dropped         = 1'b0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        kind       <= KIND_RX;
        rx_byte    <= '0;
        read_index <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_START;
        cfg_data   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_framing();
        test_payload_overflow();
        test_output_holdoff();
        test_delimiter_sweep();

        drain_results();
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule

@@ sim.f @@
sv/dpr_pkg.sv
sv/dpr_ram.sv
sv/delimited_packet_receiver_core.sv
sv/dpr_checker.sv
dv/testbench.sv
